/* src/lbfs_pkg.sv */
// Shared types, codes and table math for the LED breathe/flash sequencer.
package lbfs_pkg;

	// Event kind codes
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_MODE  = 2'd1;
	localparam logic [1:0] KIND_FLASH = 2'd2;

	// Mode codes; the last code is not a mode and is ignored
	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_WIFI   = 2'd1;
	localparam logic [1:0] MODE_PORTAL = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Config register indexes
	localparam logic [1:0] REG_FRAME_MS     = 2'd0;
	localparam logic [1:0] REG_FLASH_ON_MS  = 2'd1;
	localparam logic [1:0] REG_FLASH_OFF_MS = 2'd2;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned FRAME_W    = 10;
	localparam int unsigned MS_W       = 16;
	localparam int unsigned TIME_W     = 32;

	localparam logic [FRAME_W-1:0] FRAME_MS_RST = 10'd33;
	localparam logic [MS_W-1:0]    FLASH_MS_RST = 16'd80;

	localparam int unsigned BREATHE_PERIOD_DEF = 3000;

	// Base colours of the two breathing modes
	localparam logic [7:0] WIFI_R = 8'd255;
	localparam logic [7:0] WIFI_G = 8'd80;
	localparam logic [7:0] WIFI_B = 8'd0;
	localparam logic [7:0] PORTAL_R = 8'd0;
	localparam logic [7:0] PORTAL_G = 8'd100;
	localparam logic [7:0] PORTAL_B = 8'd255;

	// Q30 constants for the wave table
	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [63:0] PI_Q30  = 64'd3373259426;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] mode;
		logic [7:0] flash_red;
		logic [7:0] flash_green;
		logic [7:0] flash_blue;
		logic [3:0] flash_count;
	} evt_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} pix_t;

	// Breathing scale for phase p: floor(10 + 200*sin^2(pi*p/period)), Q30 fixed point.
	// Elaboration only; the division by period is a plain long division.
	function automatic logic [7:0] wave_entry(input logic [31:0] p, input logic [31:0] period);
		logic [63:0] b;
		logic [63:0] num;
		logic [63:0] rem;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] w;
		logic [63:0] e;
		b = (p <= period - p) ? {32'd0, p} : {32'd0, period - p};
		num = b * PI_Q30;
		rem = 64'd0;
		x = 64'd0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= {32'd0, period}) begin
				rem = rem - {32'd0, period};
				x[i] = 1'b1;
			end
		end
		x2 = (x * x) >> 30;
		t = Q30_ONE - x2 / 64'd72;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
		s = (x * t) >> 30;
		if (s > Q30_ONE) begin
			s = Q30_ONE;
		end
		w = (s * s) >> 30;
		e = 64'd10 + ((w * 64'd200) >> 30);
		return e[7:0];
	endfunction

endpackage

/* src/lbfs_wave_rom.sv */
// Constant breathing-scale ROM with registered read.
module lbfs_wave_rom #(
	parameter int unsigned BREATHE_PERIOD = lbfs_pkg::BREATHE_PERIOD_DEF,
	parameter int unsigned ADDR_W = $clog2(BREATHE_PERIOD)
) (
	input  logic              clk,
	input  logic [ADDR_W-1:0] addr,
	output logic [7:0]        scale
);

	typedef logic [7:0] wave_tab_t [BREATHE_PERIOD];

	function automatic wave_tab_t build_tab();
		wave_tab_t tab;
		for (int k = 0; k < int'(BREATHE_PERIOD); k++) begin
			tab[k] = lbfs_pkg::wave_entry(32'(k), 32'(BREATHE_PERIOD));
		end
		return tab;
	endfunction

	localparam wave_tab_t WAVE = build_tab();

	// registered read
	always_ff @(posedge clk) begin
		scale <= WAVE[addr];
	end

endmodule

/* src/led_breathe_flash_sequencer_unit.sv */
// Top level: LED breathe and flash sequencer.
// Flow: an accepted event is registered in the input stage and processed from there; its
// result is written to the output register and waits there until it is taken.
// Throughput: one event per cycle; the input stalls only while a stalled result waits in
// the output register and the event in flight would make another.
// Reset: all control state, timers and config registers return to defaults at once;
// the wave ROM is constant, so there is no clearing pass.
module led_breathe_flash_sequencer_unit #(
	parameter int unsigned BREATHE_PERIOD = lbfs_pkg::BREATHE_PERIOD_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                evt_valid,
	output logic                                evt_stall,
	input  lbfs_pkg::evt_t                      evt,
	output logic                                pix_valid,
	input  logic                                pix_stall,
	output lbfs_pkg::pix_t                      pix,
	input  logic                                cfg_we,
	input  logic [lbfs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lbfs_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int unsigned PHASE_W = $clog2(BREATHE_PERIOD);
	localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(BREATHE_PERIOD - 1);
	localparam int unsigned TW = lbfs_pkg::TIME_W;

	// config registers
	logic [lbfs_pkg::FRAME_W-1:0] frame_ms_q;
	logic [lbfs_pkg::MS_W-1:0]    on_ms_q;
	logic [lbfs_pkg::MS_W-1:0]    off_ms_q;

	// input stage
	logic           valid_s1;
	lbfs_pkg::evt_t evt_s1;

	// sequencer state
	logic [TW-1:0]      time_q;
	logic [TW-1:0]      last_frame_q;
	logic [TW-1:0]      start_q;
	logic [PHASE_W-1:0] next_phase_q;   // phase the next tick lands on
	logic [1:0]         mode_q;
	logic               busy_q;
	logic               lit_q;
	logic [3:0]         left_q;
	lbfs_pkg::pix_t     colour_q;

	// output register
	logic           out_valid_q;
	lbfs_pkg::pix_t out_q;

	// next-state and result
	logic [TW-1:0]      time_d;
	logic [TW-1:0]      last_frame_d;
	logic [TW-1:0]      start_d;
	logic [PHASE_W-1:0] next_phase_d;
	logic [1:0]         mode_d;
	logic               busy_d;
	logic               lit_d;
	logic [3:0]         left_d;
	lbfs_pkg::pix_t     colour_d;
	logic               has_res;
	lbfs_pkg::pix_t     res;

	logic               proceed;
	logic [TW-1:0]      time_inc;
	logic [TW-1:0]      frame_age;
	logic [TW-1:0]      elapsed;
	logic [PHASE_W-1:0] phase_inc;
	logic [PHASE_W-1:0] rom_addr;
	logic [7:0]         scale;
	logic [8:0]         scale_p1;
	logic [7:0]         base_r;
	logic [7:0]         base_g;
	logic [7:0]         base_b;
	logic [16:0]        prod_r;
	logic [16:0]        prod_g;
	logic [16:0]        prod_b;
	logic [3:0]         left_dec;

	// wave ROM, always holding the entry for next_phase_q
	lbfs_wave_rom #(
		.BREATHE_PERIOD(BREATHE_PERIOD),
		.ADDR_W(PHASE_W)
	) u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.scale(scale)
	);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_ms_q <= lbfs_pkg::FRAME_MS_RST;
			on_ms_q    <= lbfs_pkg::FLASH_MS_RST;
			off_ms_q   <= lbfs_pkg::FLASH_MS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lbfs_pkg::REG_FRAME_MS:     frame_ms_q <= cfg_data[lbfs_pkg::FRAME_W-1:0];
				lbfs_pkg::REG_FLASH_ON_MS:  on_ms_q    <= cfg_data;
				lbfs_pkg::REG_FLASH_OFF_MS: off_ms_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// shared arithmetic
	always_comb begin
		time_inc  = time_q + TW'(1);
		frame_age = time_inc - last_frame_q;
		elapsed   = time_inc - start_q;
		phase_inc = (next_phase_q == PHASE_LAST) ? '0 : next_phase_q + PHASE_W'(1);
		left_dec  = left_q - 4'd1;
		scale_p1  = {1'b0, scale} + 9'd1;
		if (mode_q == lbfs_pkg::MODE_WIFI) begin
			base_r = lbfs_pkg::WIFI_R;
			base_g = lbfs_pkg::WIFI_G;
			base_b = lbfs_pkg::WIFI_B;
		end else begin
			base_r = lbfs_pkg::PORTAL_R;
			base_g = lbfs_pkg::PORTAL_G;
			base_b = lbfs_pkg::PORTAL_B;
		end
		prod_r = 17'(base_r) * 17'(scale_p1);
		prod_g = 17'(base_g) * 17'(scale_p1);
		prod_b = 17'(base_b) * 17'(scale_p1);
	end

	// event processing
	always_comb begin
		time_d       = time_q;
		last_frame_d = last_frame_q;
		start_d      = start_q;
		next_phase_d = next_phase_q;
		mode_d       = mode_q;
		busy_d       = busy_q;
		lit_d        = lit_q;
		left_d       = left_q;
		colour_d     = colour_q;
		has_res      = 1'b0;
		res          = '0;
		case (evt_s1.kind)
			lbfs_pkg::KIND_TICK: begin
				time_d       = time_inc;
				next_phase_d = phase_inc;
				if (mode_q != lbfs_pkg::MODE_NORMAL) begin
					if (frame_age >= TW'(frame_ms_q)) begin
						last_frame_d  = time_inc;
						has_res       = 1'b1;
						res.out_red   = prod_r[15:8];
						res.out_green = prod_g[15:8];
						res.out_blue  = prod_b[15:8];
					end
				end else if (busy_q) begin
					if (lit_q) begin
						if (elapsed >= TW'(on_ms_q)) begin
							lit_d   = 1'b0;
							start_d = time_inc;
							has_res = 1'b1;
						end
					end else if (elapsed >= TW'(off_ms_q)) begin
						left_d  = left_dec;
						has_res = 1'b1;
						if (left_dec == 4'd0) begin
							busy_d = 1'b0;
						end else begin
							lit_d   = 1'b1;
							start_d = time_inc;
							res     = colour_q;
						end
					end
				end
			end
			lbfs_pkg::KIND_MODE: begin
				if (evt_s1.mode != lbfs_pkg::MODE_UNUSED && evt_s1.mode != mode_q) begin
					mode_d  = evt_s1.mode;
					busy_d  = 1'b0;
					has_res = (evt_s1.mode == lbfs_pkg::MODE_NORMAL);
				end
			end
			lbfs_pkg::KIND_FLASH: begin
				if (mode_q == lbfs_pkg::MODE_NORMAL) begin
					colour_d.out_red   = evt_s1.flash_red;
					colour_d.out_green = evt_s1.flash_green;
					colour_d.out_blue  = evt_s1.flash_blue;
					left_d  = (evt_s1.flash_count == 4'd0) ? 4'd1 : evt_s1.flash_count;
					lit_d   = 1'b1;
					start_d = time_q;
					busy_d  = 1'b1;
					has_res = 1'b1;
					res     = colour_d;
				end
			end
			default: ;
		endcase
	end

	// handshake: hold the stage only when a result would collide with a stalled one
	assign proceed   = valid_s1 && (!out_valid_q || !pix_stall || !has_res);
	assign evt_stall = valid_s1 && !proceed;
	assign rom_addr  = (proceed && evt_s1.kind == lbfs_pkg::KIND_TICK) ? phase_inc : next_phase_q;
	assign pix_valid = out_valid_q;
	assign pix       = out_q;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!evt_stall) begin
			valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!evt_stall && evt_valid) begin
			evt_s1 <= evt;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q       <= '0;
			last_frame_q <= '0;
			start_q      <= '0;
			next_phase_q <= PHASE_W'(1);
			mode_q       <= lbfs_pkg::MODE_NORMAL;
			busy_q       <= 1'b0;
			lit_q        <= 1'b0;
			left_q       <= '0;
			colour_q     <= '0;
		end else if (proceed) begin
			time_q       <= time_d;
			last_frame_q <= last_frame_d;
			start_q      <= start_d;
			next_phase_q <= next_phase_d;
			mode_q       <= mode_d;
			busy_q       <= busy_d;
			lit_q        <= lit_d;
			left_q       <= left_d;
			colour_q     <= colour_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proceed && has_res) begin
			out_valid_q <= 1'b1;
		end else if (!pix_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed && has_res) begin
			out_q <= res;
		end
	end

endmodule

/* src/lbfs_checker.sv */
// Port-level checker for the sequencer, bound to the top level.
module lbfs_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           evt_stall,
	input lbfs_pkg::pix_t pix,
	input logic           pix_valid,
	input logic           pix_stall
);

	// a stalled result transaction holds
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> pix_valid && $stable(pix))
		else $error("result changed while stalled");

	// input backpressure only comes from a stalled, full output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		evt_stall |-> pix_valid && pix_stall)
		else $error("input stalled without output backpressure");

	// reset empties the block once it has seen an edge in reset
	a_reset_idle: assert property (@(posedge clk)
		!arst_n ##1 !arst_n |-> !pix_valid && !evt_stall)
		else $error("activity during reset");

	// once the output frees up, a stalled input is taken at that edge
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		evt_stall ##1 !pix_stall |-> !evt_stall)
		else $error("input stall outlived output backpressure");

endmodule

bind led_breathe_flash_sequencer_unit lbfs_checker u_lbfs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.evt_stall(evt_stall),
	.pix      (pix),
	.pix_valid(pix_valid),
	.pix_stall(pix_stall)
);

/* test/led_breathe_flash_sequencer_unit_test.sv */
// Testbench for the LED breathe/flash sequencer: random traffic checked against a colour tracker.

// Tracks the strip colour the sequencer should produce and checks each pixel transaction
class strip_colour_tracker;
	bit [7:0]       wave_scale [4096];
	bit [31:0]      now_ms;
	bit [31:0]      frame_mark;
	bit [31:0]      step_mark;
	bit [11:0]      phase;
	bit [1:0]       mode;
	bit             flashing;
	bit             lit;
	bit [3:0]       flashes_left;
	lbfs_pkg::pix_t flash_colour;
	bit [9:0]       frame_len;
	bit [15:0]      on_len;
	bit [15:0]      off_len;
	lbfs_pkg::pix_t due_colours [$];
	int             errors;

	function new();
		for (int p = 0; p < 4096; p++) begin
			wave_scale[p] = (p < lbfs_pkg::BREATHE_PERIOD_DEF) ? scale_at(p) : 8'd0;
		end
		frame_len = 10'd33;
		on_len = 16'd80;
		off_len = 16'd80;
	endfunction

	// Breathing level 10 + 200*sin^2(pi*p/period), fixed point Q30
	function bit [7:0] scale_at(bit [63:0] p);
		bit [63:0] period;
		bit [63:0] half;
		bit [63:0] ang;
		bit [63:0] ang2;
		bit [63:0] poly;
		bit [63:0] sn;
		bit [63:0] sq;
		bit [63:0] lvl;
		period = lbfs_pkg::BREATHE_PERIOD_DEF;
		half = (p <= period - p) ? p : period - p;
		ang = (half * lbfs_pkg::PI_Q30) / period;
		ang2 = (ang * ang) >> 30;
		// Taylor series of sin, innermost term first
		poly = lbfs_pkg::Q30_ONE - ang2 / 72;
		poly = lbfs_pkg::Q30_ONE - ((ang2 * poly) >> 30) / 42;
		poly = lbfs_pkg::Q30_ONE - ((ang2 * poly) >> 30) / 20;
		poly = lbfs_pkg::Q30_ONE - ((ang2 * poly) >> 30) / 6;
		sn = (ang * poly) >> 30;
		if (sn > lbfs_pkg::Q30_ONE) begin
			sn = lbfs_pkg::Q30_ONE;
		end
		sq = (sn * sn) >> 30;
		lvl = 64'd10 + ((sq * 64'd200) >> 30);
		return lvl[7:0];
	endfunction

	function void set_reg(bit [1:0] index, bit [15:0] value);
		case (index)
			lbfs_pkg::REG_FRAME_MS:     frame_len = value[9:0];
			lbfs_pkg::REG_FLASH_ON_MS:  on_len = value;
			lbfs_pkg::REG_FLASH_OFF_MS: off_len = value;
			default: ;
		endcase
	endfunction

	function lbfs_pkg::pix_t dim(bit [7:0] r, bit [7:0] g, bit [7:0] b, bit [7:0] s);
		lbfs_pkg::pix_t c;
		int unsigned k;
		k = s + 1;
		c.out_red = 8'((r * k) >> 8);
		c.out_green = 8'((g * k) >> 8);
		c.out_blue = 8'((b * k) >> 8);
		return c;
	endfunction

	// One millisecond: breathing frame or flash step
	function void tick();
		bit [31:0] elapsed;
		bit [7:0]  s;
		now_ms++;
		phase = (phase == lbfs_pkg::BREATHE_PERIOD_DEF - 1) ? 12'd0 : phase + 12'd1;
		if (mode != lbfs_pkg::MODE_NORMAL) begin
			if (now_ms - frame_mark < frame_len) return;
			frame_mark = now_ms;
			s = wave_scale[phase];
			if (mode == lbfs_pkg::MODE_WIFI) begin
				due_colours.push_back(dim(lbfs_pkg::WIFI_R, lbfs_pkg::WIFI_G, lbfs_pkg::WIFI_B, s));
			end else begin
				due_colours.push_back(dim(lbfs_pkg::PORTAL_R, lbfs_pkg::PORTAL_G,
					lbfs_pkg::PORTAL_B, s));
			end
			return;
		end
		if (!flashing) return;
		elapsed = now_ms - step_mark;
		if (lit) begin
			if (elapsed < on_len) return;
			lit = 0;
			step_mark = now_ms;
			due_colours.push_back('0);
			return;
		end
		if (elapsed < off_len) return;
		flashes_left--;
		if (flashes_left == 0) begin
			flashing = 0;
			due_colours.push_back('0);
		end else begin
			lit = 1;
			step_mark = now_ms;
			due_colours.push_back(flash_colour);
		end
	endfunction

	// Accepted event transaction
	function void take_event(lbfs_pkg::evt_t e);
		case (e.kind)
			lbfs_pkg::KIND_TICK: tick();
			lbfs_pkg::KIND_MODE: begin
				if ((e.mode == lbfs_pkg::MODE_NORMAL || e.mode == lbfs_pkg::MODE_WIFI ||
						e.mode == lbfs_pkg::MODE_PORTAL) && e.mode != mode) begin
					mode = e.mode;
					flashing = 0;
					if (mode == lbfs_pkg::MODE_NORMAL) due_colours.push_back('0);
				end
			end
			lbfs_pkg::KIND_FLASH: begin
				if (mode == lbfs_pkg::MODE_NORMAL) begin
					flash_colour = {e.flash_red, e.flash_green, e.flash_blue};
					flashes_left = (e.flash_count == 0) ? 4'd1 : e.flash_count;
					lit = 1;
					step_mark = now_ms;
					flashing = 1;
					due_colours.push_back(flash_colour);
				end
			end
			default: ;
		endcase
	endfunction

	// Accepted pixel transaction against the oldest due colour
	function void check_colour(lbfs_pkg::pix_t got);
		lbfs_pkg::pix_t want;
		if (due_colours.size() == 0) begin
			errors++;
			$display("%0t: unexpected pixel, expected none got %h", $time, got);
			return;
		end
		want = due_colours.pop_front();
		if (got.out_red != want.out_red) begin
			errors++;
			$display("%0t: out_red expected %0d got %0d", $time, want.out_red, got.out_red);
		end
		if (got.out_green != want.out_green) begin
			errors++;
			$display("%0t: out_green expected %0d got %0d", $time, want.out_green, got.out_green);
		end
		if (got.out_blue != want.out_blue) begin
			errors++;
			$display("%0t: out_blue expected %0d got %0d", $time, want.out_blue, got.out_blue);
		end
	endfunction

	function int outstanding();
		return due_colours.size();
	endfunction
endclass

module led_breathe_flash_sequencer_unit_test;

	localparam logic [1:0] KIND_BAD = 2'd3;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 6;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            evt_valid = 1'b0;
	logic                            evt_stall;
	lbfs_pkg::evt_t                  evt = '0;
	logic                            pix_valid;
	logic                            pix_stall = 1'b0;
	lbfs_pkg::pix_t                  pix;
	logic                            cfg_we = 1'b0;
	logic [lbfs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [lbfs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	strip_colour_tracker strip;
	bit calm;
	int hold_asks;
	int items_sent;

	led_breathe_flash_sequencer_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial forever #5 clk = ~clk;

	// Mostly no gap, some short ones, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic lbfs_pkg::evt_t random_event();
		logic [31:0] r;
		r = $urandom;
		return r[$bits(lbfs_pkg::evt_t)-1:0];
	endfunction

	function automatic lbfs_pkg::evt_t tick_event();
		lbfs_pkg::evt_t e;
		e = random_event();
		e.kind = lbfs_pkg::KIND_TICK;
		return e;
	endfunction

	function automatic lbfs_pkg::evt_t mode_event(logic [1:0] m);
		lbfs_pkg::evt_t e;
		e = random_event();
		e.kind = lbfs_pkg::KIND_MODE;
		e.mode = m;
		return e;
	endfunction

	function automatic lbfs_pkg::evt_t flash_event(logic [7:0] r, logic [7:0] g,
			logic [7:0] b, logic [3:0] n);
		lbfs_pkg::evt_t e;
		e = random_event();
		e.kind = lbfs_pkg::KIND_FLASH;
		e.flash_red = r;
		e.flash_green = g;
		e.flash_blue = b;
		e.flash_count = n;
		return e;
	endfunction

	// Offer one event transaction and hold it until accepted
	task automatic send_event(input lbfs_pkg::evt_t e);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt <= e;
		evt_valid <= 1'b1;
		@(posedge clk);
		while (evt_stall) @(posedge clk);
		strip.take_event(e);
		items_sent++;
	endtask

	// Pause input until every due colour has come out, then let the pipe settle
	task automatic wait_for_colours();
		evt_valid <= 1'b0;
		while (strip.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		strip.set_reg(index, value);
	endtask

	task automatic set_timing(input logic [15:0] frame, input logic [15:0] on,
			input logic [15:0] off);
		wait_for_colours();
		write_reg(lbfs_pkg::REG_FRAME_MS, frame);
		write_reg(lbfs_pkg::REG_FLASH_ON_MS, on);
		write_reg(lbfs_pkg::REG_FLASH_OFF_MS, off);
		cfg_we <= 1'b0;
	endtask

	// Flash runs, breathing runs and noise, with random content
	task automatic run_mix(input int target);
		int stop;
		int pick;
		int n;
		stop = items_sent + target;
		while (items_sent < stop) begin
			pick = $urandom_range(0, 19);
			if (pick < 8) begin
				send_event(mode_event(lbfs_pkg::MODE_NORMAL));
				send_event(flash_event(8'($urandom), 8'($urandom), 8'($urandom),
					4'($urandom)));
				n = $urandom_range(3, 60);
				repeat (n) send_event(tick_event());
			end else if (pick < 15) begin
				send_event(mode_event($urandom_range(0, 1) ? lbfs_pkg::MODE_WIFI :
					lbfs_pkg::MODE_PORTAL));
				n = $urandom_range(5, 40);
				repeat (n) send_event(tick_event());
			end else if (pick < 19) begin
				n = $urandom_range(1, 6);
				repeat (n) send_event(random_event());
			end else begin
				wait_for_colours();
			end
		end
	endtask

	// Receiver: check pixels, random stalls, and a long hold-off on request
	initial begin
		int stall_left;
		int hold_seen;
		stall_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pix_valid && !pix_stall) strip.check_colour(pix);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && !calm) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				pix_stall <= 1'b1;
				stall_left--;
			end else begin
				pix_stall <= 1'b0;
			end
		end
	end

	// Watchdog: too long without any transaction on either side
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((evt_valid && !evt_stall) || (pix_valid && !pix_stall)) quiet = 0;
			else quiet++;
		end
		$display("%0t: watchdog, no transaction for %0d cycles", $time, QUIET_LIMIT);
		$display("status: fail");
		$finish;
	end

	// Stimulus
	initial begin
		strip = new();
		calm = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset timing: one breathing frame after 33 ms
		send_event(mode_event(lbfs_pkg::MODE_WIFI));
		repeat (34) send_event(tick_event());
		send_event(mode_event(lbfs_pkg::MODE_NORMAL));

		// Directed: frame register zero, short flash timing
		set_timing(16'd0, 16'd2, 16'd1);
		send_event(flash_event(8'hff, 8'h00, 8'hff, 4'd0));
		repeat (3) send_event(tick_event());
		send_event(flash_event(8'h00, 8'hff, 8'h00, 4'd15));
		repeat (3) send_event(tick_event());
		send_event(flash_event(8'hff, 8'hff, 8'hff, 4'd1));
		send_event(mode_event(lbfs_pkg::MODE_NORMAL));
		send_event(mode_event(lbfs_pkg::MODE_UNUSED));
		begin
			lbfs_pkg::evt_t e;
			e = random_event();
			e.kind = KIND_BAD;
			send_event(e);
		end
		send_event(mode_event(lbfs_pkg::MODE_WIFI));
		send_event(flash_event(8'h12, 8'h34, 8'h56, 4'd3));
		repeat (2) send_event(tick_event());
		send_event(mode_event(lbfs_pkg::MODE_PORTAL));
		repeat (2) send_event(tick_event());
		send_event(mode_event(lbfs_pkg::MODE_NORMAL));
		send_event(tick_event());

		// Zero on and off times
		calm = 1'b0;
		set_timing(16'd1, 16'd0, 16'd0);
		run_mix(60);

		// Largest values; all data bits set on the frame write
		set_timing(16'hffff, 16'hffff, 16'hffff);
		run_mix(40);

		// Receiver holds off while breathing frames pile up
		set_timing(16'd0, 16'd3, 16'd2);
		send_event(mode_event(lbfs_pkg::MODE_WIFI));
		hold_asks <= hold_asks + 1;
		repeat (40) send_event(tick_event());
		send_event(mode_event(lbfs_pkg::MODE_NORMAL));

		// Random timing settings
		repeat (5) begin
			set_timing(16'($urandom_range(0, 40)), 16'($urandom_range(0, 12)),
				16'($urandom_range(0, 12)));
			calm = ($urandom_range(0, 3) == 0);
			run_mix(80);
		end

		calm = 1'b0;
		wait_for_colours();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (strip.errors == 0 && strip.outstanding() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

/* files.f */
src/lbfs_pkg.sv
src/lbfs_wave_rom.sv
src/led_breathe_flash_sequencer_unit.sv
src/lbfs_checker.sv
test/led_breathe_flash_sequencer_unit_test.sv
